@@ hdl/smf_pkg.sv @@
// Shared types, codes and saturation helpers of the sparse factorization engine
package smf_pkg;

	localparam int MAX_ROWS_DEF     = 256;
	localparam int MAX_COLS_DEF     = 256;
	localparam int MAX_FEATURES_DEF = 8;
	localparam int MAX_RATINGS_DEF  = 4096;

	// Gradient accumulator and one product term (floor of a 64 bit product by 2^16)
	localparam int ACC_W  = 48;
	localparam int TERM_W = 48;

	localparam logic signed [ACC_W+1:0] ACC_HI = 50'sh0_4000_0000_0000;
	localparam logic signed [ACC_W+1:0] ACC_LO = -50'sh0_4000_0000_0000;
	localparam logic signed [50:0] SAT_HI = 51'sh7FFF_FFFF;
	localparam logic signed [50:0] SAT_LO = -51'sh8000_0000;

	localparam logic [15:0] LR_RESET    = 16'd328;
	localparam logic [15:0] ITERS_RESET = 16'd1;
	localparam logic [3:0]  FEAT_RESET  = 4'd2;
	localparam logic [8:0]  ROWS_RESET  = 9'd256;
	localparam logic [8:0]  COLS_RESET  = 9'd256;

	typedef enum logic [2:0] {
		OP_LOAD_RATING = 3'd0,
		OP_LOAD_LEFT   = 3'd1,
		OP_LOAD_RIGHT  = 3'd2,
		OP_RUN         = 3'd3,
		OP_READ        = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_LEARNING_RATE = 3'd0,
		REG_ITERATIONS    = 3'd1,
		REG_FEATURES      = 3'd2,
		REG_ROWS          = 3'd3,
		REG_COLS          = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DOT,
		S_CLEAR,
		S_FETCH,
		S_RDOT,
		S_GRAD,
		S_UPD
	} state_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [7:0]         row_index;
		logic [7:0]         col_index;
		logic [2:0]         feature_index;
		logic signed [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               run_done;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic [7:0]         row;
		logic [7:0]         col;
		logic signed [31:0] value;
	} rating_t;

	// Write strobes broadcast to every feature cell
	typedef struct packed {
		logic ld_left;
		logic ld_right;
		logic clr_gl;
		logic clr_gr;
		logic acc_gl;
		logic acc_gr;
		logic upd_left;
		logic upd_right;
	} cell_ctl_t;

	function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [ACC_W+1:0] x);
		logic signed [ACC_W+1:0] y;
		begin
			if (x > ACC_HI)
				y = ACC_HI;
			else if (x < ACC_LO)
				y = ACC_LO;
			else
				y = x;
			return y[ACC_W-1:0];
		end
	endfunction

	function automatic logic signed [31:0] sat32w(input logic signed [50:0] x);
		logic signed [50:0] y;
		begin
			if (x > SAT_HI)
				y = SAT_HI;
			else if (x < SAT_LO)
				y = SAT_LO;
			else
				y = x;
			return y[31:0];
		end
	endfunction

endpackage

@@ hdl/smf_cell.sv @@
// One feature cell: its column of L, row of R, gradient stores and a link of the sum chain
module smf_cell #(
	parameter int MAX_ROWS = smf_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = smf_pkg::MAX_COLS_DEF,
	parameter int CELL_IDX = 0,
	parameter int SUM_W    = 52,
	localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CA_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic                    clk,
	input  smf_pkg::cell_ctl_t      ctl,
	input  logic [RA_W-1:0]         row_addr,
	input  logic [CA_W-1:0]         col_addr,
	input  logic [2:0]              feature,
	input  logic [3:0]              nf,
	input  logic signed [31:0]      value,
	input  logic signed [32:0]      err,
	input  logic [15:0]             alpha,
	input  logic signed [SUM_W-1:0] sum_in,
	output logic signed [SUM_W-1:0] sum_out
);

	localparam int AW = smf_pkg::ACC_W;

	logic signed [31:0]   lmem  [MAX_ROWS];
	logic signed [31:0]   rmem  [MAX_COLS];
	logic signed [AW-1:0] glmem [MAX_ROWS];
	logic signed [AW-1:0] grmem [MAX_COLS];

	logic signed [31:0]   l_q, r_q;
	logic signed [AW-1:0] gl_q, gr_q;
	logic signed [63:0]   prod_s1;
	logic signed [64:0]   dl_s1, dr_s1;
	logic signed [65:0]   stl_s1, str_s1;
	logic signed [SUM_W-1:0] sum_q;

	logic active, sel;
	logic signed [smf_pkg::TERM_W-1:0] term;
	logic signed [48:0] dl_term, dr_term, gl_neg2, gr_neg2;
	logic signed [49:0] stl_term, str_term;
	logic signed [31:0] new_l, new_r, l_wdata, r_wdata;
	logic signed [AW-1:0] gl_wdata, gr_wdata;
	logic l_we, r_we, gl_we, gr_we;

	assign active = (CELL_IDX < int'(nf));
	assign sel    = (int'(feature) == CELL_IDX);

	// Registered reads at the broadcast addresses
	always_ff @(posedge clk) begin
		l_q  <= lmem[row_addr];
		r_q  <= rmem[col_addr];
		gl_q <= glmem[row_addr];
		gr_q <= grmem[col_addr];
	end

	assign term    = prod_s1[63:16];
	assign dl_term = dl_s1[64:16];
	assign dr_term = dr_s1[64:16];
	assign gl_neg2 = -{gl_q, 1'b0};
	assign gr_neg2 = -{gr_q, 1'b0};
	assign stl_term = stl_s1[65:16];
	assign str_term = str_s1[65:16];

	always_ff @(posedge clk) begin
		prod_s1 <= l_q * r_q;
		dl_s1   <= err * r_q;
		dr_s1   <= err * l_q;
		stl_s1  <= $signed({1'b0, alpha}) * gl_neg2;
		str_s1  <= $signed({1'b0, alpha}) * gr_neg2;
		sum_q   <= sum_in + (active ? SUM_W'(term) : '0);
	end

	assign sum_out = sum_q;

	assign new_l = smf_pkg::sat32w({{19{l_q[31]}}, l_q} - {stl_term[49], stl_term});
	assign new_r = smf_pkg::sat32w({{19{r_q[31]}}, r_q} - {str_term[49], str_term});

	assign l_we    = (ctl.ld_left && sel) || (ctl.upd_left && active);
	assign r_we    = (ctl.ld_right && sel) || (ctl.upd_right && active);
	assign l_wdata = ctl.ld_left ? value : new_l;
	assign r_wdata = ctl.ld_right ? value : new_r;

	assign gl_we    = ctl.clr_gl || (ctl.acc_gl && active);
	assign gr_we    = ctl.clr_gr || (ctl.acc_gr && active);
	assign gl_wdata = ctl.clr_gl ? '0 :
		smf_pkg::clamp_acc({{2{gl_q[AW-1]}}, gl_q} + {dl_term[48], dl_term});
	assign gr_wdata = ctl.clr_gr ? '0 :
		smf_pkg::clamp_acc({{2{gr_q[AW-1]}}, gr_q} + {dr_term[48], dr_term});

	always_ff @(posedge clk) begin
		if (l_we)
			lmem[row_addr] <= l_wdata;
	end

	always_ff @(posedge clk) begin
		if (r_we)
			rmem[col_addr] <= r_wdata;
	end

	always_ff @(posedge clk) begin
		if (gl_we)
			glmem[row_addr] <= gl_wdata;
	end

	always_ff @(posedge clk) begin
		if (gr_we)
			grmem[col_addr] <= gr_wdata;
	end

endmodule

@@ hdl/smf_rstore.sv @@
// Rating list memory: row, column and value of every known entry in load order
module smf_rstore #(
	parameter int MAX_RATINGS = smf_pkg::MAX_RATINGS_DEF,
	localparam int AW = (MAX_RATINGS > 1) ? $clog2(MAX_RATINGS) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  smf_pkg::rating_t wdata,
	input  logic [AW-1:0]    raddr,
	output smf_pkg::rating_t rdata
);

	smf_pkg::rating_t mem [MAX_RATINGS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/sparse_matrix_factorization_gd.sv @@
// Top level of the sparse matrix factorization engine (gradient descent on L and R)
//
//  channel   dir  handshake                  payload
//  req       in   req_valid / req_stall      smf_pkg::req_t (op, indices, value)
//  rsp       out  rsp_valid / rsp_stall      smf_pkg::rsp_t (value, run_done, status)
//  cfg       in   cfg_we                     cfg_index, cfg_data
//
// A read sends the sum down the chain of feature cells, one cell a cycle. A gradient
// step is a clear sweep over the larger of the row and column counts, one pass of every
// rating through the cell chain, then an update sweep over that same count of rows.
// Reset clears the control state and the rating count; factor stores hold garbage until
// loaded. A stalled response holds; a new request is taken in the cycle it leaves.
module sparse_matrix_factorization_gd #(
	parameter int MAX_ROWS     = smf_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS     = smf_pkg::MAX_COLS_DEF,
	parameter int MAX_FEATURES = smf_pkg::MAX_FEATURES_DEF,
	parameter int MAX_RATINGS  = smf_pkg::MAX_RATINGS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  smf_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output smf_pkg::rsp_t  rsp,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data
);

	localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CA_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RT_AW = (MAX_RATINGS > 1) ? $clog2(MAX_RATINGS) : 1;
	localparam int CNT_W = $clog2(MAX_RATINGS + 1);
	localparam int SUM_W = smf_pkg::TERM_W + $clog2(MAX_FEATURES + 1) + 1;
	localparam int DOT_WAIT = MAX_FEATURES + 3;
	localparam int SW = $clog2(((DOT_WAIT + 1) > 512) ? (DOT_WAIT + 1) : 512);

	localparam logic signed [SUM_W-1:0] B_HI = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] B_LO = SUM_W'(-64'sd2147483648);

	// Configuration
	logic [15:0] lr_q, iters_q;
	logic [3:0]  feat_q;
	logic [8:0]  rows_q, cols_q;
	logic [3:0]  nf;
	logic [8:0]  nr, nc, lim;

	// Sequencer
	smf_pkg::state_t state_q, state_d;
	logic [SW-1:0]    cnt_q, cnt_d;
	logic [1:0]       ph_q, ph_d;
	logic [CNT_W-1:0] n_q, n_d, rcount_q, rcount_d;
	logic [15:0]      it_q, it_d;
	logic [7:0]       row_q, row_d, col_q, col_d;
	logic signed [32:0] d_q, d_d;
	logic             skip_q, skip_d;

	// Response register
	logic          rsp_valid_q, produce;
	smf_pkg::rsp_t rsp_q, rsp_d;

	logic               accept, rs_we;
	smf_pkg::rating_t   rs_wdata, rt;
	smf_pkg::cell_ctl_t ctl;
	logic [RA_W-1:0]    row_addr;
	logic [CA_W-1:0]    col_addr;
	logic signed [SUM_W-1:0] chain [MAX_FEATURES+1];
	logic signed [SUM_W-1:0] chain_out;
	logic signed [31:0] b_sat;
	logic rc_ok, lf_ok, rf_ok, full, rt_ok;

	// Clamp the counts in use to their legal ranges
	always_comb begin
		if (feat_q == '0)
			nf = 4'd1;
		else if (int'(feat_q) > MAX_FEATURES)
			nf = 4'(MAX_FEATURES);
		else
			nf = feat_q;
		if (rows_q == '0)
			nr = 9'd1;
		else if (int'(rows_q) > MAX_ROWS)
			nr = 9'(MAX_ROWS);
		else
			nr = rows_q;
		if (cols_q == '0)
			nc = 9'd1;
		else if (int'(cols_q) > MAX_COLS)
			nc = 9'(MAX_COLS);
		else
			nc = cols_q;
	end

	assign lim = (nr > nc) ? nr : nc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q    <= smf_pkg::LR_RESET;
			iters_q <= smf_pkg::ITERS_RESET;
			feat_q  <= smf_pkg::FEAT_RESET;
			rows_q  <= smf_pkg::ROWS_RESET;
			cols_q  <= smf_pkg::COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				smf_pkg::REG_LEARNING_RATE: lr_q    <= cfg_data;
				smf_pkg::REG_ITERATIONS:    iters_q <= cfg_data;
				smf_pkg::REG_FEATURES:      feat_q  <= cfg_data[3:0];
				smf_pkg::REG_ROWS:          rows_q  <= cfg_data[8:0];
				smf_pkg::REG_COLS:          cols_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Take a request only when idle and the response slot is free or draining
	assign req_stall = (state_q != smf_pkg::S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;

	assign rc_ok = ({1'b0, req.row_index} < nr) && ({1'b0, req.col_index} < nc);
	assign lf_ok = ({1'b0, req.row_index} < nr) && ({1'b0, req.feature_index} < nf);
	assign rf_ok = ({1'b0, req.feature_index} < nf) && ({1'b0, req.col_index} < nc);
	assign full  = (rcount_q == CNT_W'(MAX_RATINGS));
	assign rt_ok = ({1'b0, rt.row} < nr) && ({1'b0, rt.col} < nc);

	assign rs_wdata = '{row: req.row_index, col: req.col_index, value: req.value_in};

	smf_rstore #(
		.MAX_RATINGS(MAX_RATINGS)
	) u_rstore (
		.clk   (clk),
		.we    (rs_we),
		.waddr (rcount_q[RT_AW-1:0]),
		.wdata (rs_wdata),
		.raddr (n_q[RT_AW-1:0]),
		.rdata (rt)
	);

	// Chain of feature cells; each active cell adds its product term to the running sum
	assign chain[0] = '0;
	for (genvar k = 0; k < MAX_FEATURES; k++) begin : g_cell
		smf_cell #(
			.MAX_ROWS (MAX_ROWS),
			.MAX_COLS (MAX_COLS),
			.CELL_IDX (k),
			.SUM_W    (SUM_W)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.row_addr (row_addr),
			.col_addr (col_addr),
			.feature  (req.feature_index),
			.nf       (nf),
			.value    (req.value_in),
			.err      (d_q),
			.alpha    (lr_q),
			.sum_in   (chain[k]),
			.sum_out  (chain[k+1])
		);
	end

	assign chain_out = chain[MAX_FEATURES];

	always_comb begin
		if (chain_out > B_HI)
			b_sat = 32'sh7FFF_FFFF;
		else if (chain_out < B_LO)
			b_sat = -32'sh8000_0000;
		else
			b_sat = chain_out[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= smf_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ph_q     <= '0;
			n_q      <= '0;
			rcount_q <= '0;
			it_q     <= '0;
			row_q    <= '0;
			col_q    <= '0;
			skip_q   <= 1'b1;
		end else begin
			cnt_q    <= cnt_d;
			ph_q     <= ph_d;
			n_q      <= n_d;
			rcount_q <= rcount_d;
			it_q     <= it_d;
			row_q    <= row_d;
			col_q    <= col_d;
			skip_q   <= skip_d;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= d_d;
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ph_d     = ph_q;
		n_d      = n_q;
		rcount_d = rcount_q;
		it_d     = it_q;
		row_d    = row_q;
		col_d    = col_q;
		d_d      = d_q;
		skip_d   = skip_q;
		rs_we    = 1'b0;
		ctl      = '0;
		produce  = 1'b0;
		rsp_d    = '{result_value: '0, run_done: 1'b0, status: smf_pkg::ST_OK};
		row_addr = RA_W'(row_q);
		col_addr = CA_W'(col_q);

		unique case (state_q)
			smf_pkg::S_IDLE: begin
				row_addr = RA_W'(req.row_index);
				col_addr = CA_W'(req.col_index);
				if (accept) begin
					row_d = req.row_index;
					col_d = req.col_index;
					unique case (req.op)
						smf_pkg::OP_LOAD_RATING: begin
							produce = 1'b1;
							if (!rc_ok)
								rsp_d.status = smf_pkg::ST_RANGE;
							else if (full)
								rsp_d.status = smf_pkg::ST_FULL;
							else begin
								rs_we    = 1'b1;
								rcount_d = rcount_q + 1'b1;
							end
						end
						smf_pkg::OP_LOAD_LEFT: begin
							produce = 1'b1;
							if (lf_ok)
								ctl.ld_left = 1'b1;
							else
								rsp_d.status = smf_pkg::ST_RANGE;
						end
						smf_pkg::OP_LOAD_RIGHT: begin
							produce = 1'b1;
							if (rf_ok)
								ctl.ld_right = 1'b1;
							else
								rsp_d.status = smf_pkg::ST_RANGE;
						end
						smf_pkg::OP_RUN: begin
							if (iters_q == '0) begin
								produce        = 1'b1;
								rsp_d.run_done = 1'b1;
							end else begin
								state_d = smf_pkg::S_CLEAR;
								cnt_d   = '0;
								it_d    = '0;
							end
						end
						smf_pkg::OP_READ: begin
							if (rc_ok) begin
								state_d = smf_pkg::S_DOT;
								cnt_d   = '0;
							end else begin
								produce      = 1'b1;
								rsp_d.status = smf_pkg::ST_RANGE;
							end
						end
						default: ; // drop unused ops
					endcase
				end
			end
			smf_pkg::S_DOT: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == SW'(DOT_WAIT)) begin
					produce            = 1'b1;
					rsp_d.result_value = b_sat;
					state_d            = smf_pkg::S_IDLE;
				end
			end
			smf_pkg::S_CLEAR: begin
				row_addr   = RA_W'(cnt_q);
				col_addr   = CA_W'(cnt_q);
				ctl.clr_gl = (cnt_q < SW'(nr));
				ctl.clr_gr = (cnt_q < SW'(nc));
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == SW'(lim - 9'd1)) begin
					n_d     = '0;
					state_d = smf_pkg::S_FETCH;
				end
			end
			smf_pkg::S_FETCH: begin
				row_addr = RA_W'(rt.row);
				col_addr = CA_W'(rt.col);
				cnt_d    = '0;
				ph_d     = '0;
				if (n_q == rcount_q)
					state_d = smf_pkg::S_UPD;
				else
					state_d = smf_pkg::S_RDOT;
			end
			smf_pkg::S_RDOT: begin
				row_addr = RA_W'(rt.row);
				col_addr = CA_W'(rt.col);
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == SW'(DOT_WAIT)) begin
					d_d     = {rt.value[31], rt.value} - {b_sat[31], b_sat};
					skip_d  = !rt_ok;
					cnt_d   = '0;
					state_d = smf_pkg::S_GRAD;
				end
			end
			smf_pkg::S_GRAD: begin
				row_addr = RA_W'(rt.row);
				col_addr = CA_W'(rt.col);
				cnt_d    = cnt_q + 1'b1;
				// once the error products are registered, fold them in
				if (cnt_q == SW'(1)) begin
					ctl.acc_gl = !skip_q;
					ctl.acc_gr = !skip_q;
					n_d        = n_q + 1'b1;
					state_d    = smf_pkg::S_FETCH;
				end
			end
			smf_pkg::S_UPD: begin
				row_addr = RA_W'(cnt_q);
				col_addr = CA_W'(cnt_q);
				ph_d     = ph_q + 2'd1;
				if (ph_q == 2'd2) begin
					ctl.upd_left  = (cnt_q < SW'(nr));
					ctl.upd_right = (cnt_q < SW'(nc));
					ph_d          = '0;
					cnt_d         = cnt_q + 1'b1;
					if (cnt_q == SW'(lim - 9'd1)) begin
						cnt_d = '0;
						if (it_q + 16'd1 == iters_q) begin
							produce        = 1'b1;
							rsp_d.run_done = 1'b1;
							state_d        = smf_pkg::S_IDLE;
						end else begin
							it_d    = it_q + 16'd1;
							state_d = smf_pkg::S_CLEAR;
						end
					end
				end
			end
			default: state_d = smf_pkg::S_IDLE;
		endcase
	end

	// Response slot: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (produce)
			rsp_valid_q <= 1'b1;
		else if (rsp_valid_q && !rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (produce)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != smf_pkg::S_IDLE) |-> req_stall)
		else $error("request taken while the sequencer is busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcount_q <= CNT_W'(MAX_RATINGS))
		else $error("rating count beyond store depth");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.run_done) |->
		(rsp.result_value == '0 && rsp.status == smf_pkg::ST_OK))
		else $error("run completion carries data or an error");

	a_grad_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smf_pkg::S_GRAD) |-> (n_q < rcount_q))
		else $error("gradient pass past the rating list");

	a_upd_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smf_pkg::S_UPD) |-> (ph_q != 2'd3))
		else $error("update phase counter overran");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the sparse matrix factorization engine
`timescale 1ns / 100ps

module tb;

	localparam int NR_MAX = 256;
	localparam int NC_MAX = 256;
	localparam int NF_MAX = 8;
	localparam int RATINGS_MAX = 4096;
	localparam int LOADED = 32;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_START = 300;
	localparam int HOLD_LEN = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_stall;
	smf_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	smf_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	sparse_matrix_factorization_gd u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the engine state
	int unsigned lr_q, iters_q, feat_q, rows_q, cols_q;
	logic [7:0] sh_row [RATINGS_MAX];
	logic [7:0] sh_col [RATINGS_MAX];
	int sh_rating [RATINGS_MAX];
	int sh_prod [RATINGS_MAX];
	int n_stored;
	int lf [NR_MAX*NF_MAX];
	int rf [NF_MAX*NC_MAX];
	int nl [NR_MAX*NF_MAX];
	int nrt [NF_MAX*NC_MAX];
	longint gl [NR_MAX*NF_MAX];
	longint gr [NF_MAX*NC_MAX];

	smf_pkg::req_t pending_req [$];
	smf_pkg::rsp_t want_rsp [$];
	int errors = 0;
	int n_checked = 0;
	int n_runs = 0;
	int cyc = 0;

	function automatic int unsigned clamp_cnt(int unsigned x, int unsigned hi);
		return x < 1 ? 1 : (x > hi ? hi : x);
	endfunction

	function automatic int sat_word(longint x);
		if (x > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (x < -64'sd2147483648)
			return 32'h8000_0000;
		return int'(x);
	endfunction

	function automatic longint clamp_grad(longint x);
		longint lim;
		lim = longint'(1) <<< 46;
		return x > lim ? lim : (x < -lim ? -lim : x);
	endfunction

	function automatic int product_at(int i, int j, int nf);
		longint s;
		s = 0;
		for (int k = 0; k < nf; k++)
			s += (longint'(lf[i*NF_MAX+k]) * longint'(rf[k*NC_MAX+j])) >>> 16;
		return sat_word(s);
	endfunction

	task automatic descend_once(int nr, int nc, int nf);
		longint d, alpha, stp;
		int i, j;
		alpha = longint'(lr_q);
		for (int n = 0; n < n_stored; n++)
			if (sh_row[n] < nr && sh_col[n] < nc)
				sh_prod[n] = product_at(sh_row[n], sh_col[n], nf);
		for (int x = 0; x < NR_MAX*NF_MAX; x++) begin
			gl[x] = 0;
			gr[x] = 0;
		end
		for (int n = 0; n < n_stored; n++) begin
			i = sh_row[n];
			j = sh_col[n];
			if (i >= nr || j >= nc)
				continue;
			d = longint'(sh_rating[n]) - longint'(sh_prod[n]);
			for (int k = 0; k < nf; k++) begin
				gl[i*NF_MAX+k] = clamp_grad(gl[i*NF_MAX+k] + ((d * rf[k*NC_MAX+j]) >>> 16));
				gr[k*NC_MAX+j] = clamp_grad(gr[k*NC_MAX+j] + ((d * lf[i*NF_MAX+k]) >>> 16));
			end
		end
		for (i = 0; i < nr; i++)
			for (int k = 0; k < nf; k++) begin
				stp = (alpha * (-2 * gl[i*NF_MAX+k])) >>> 16;
				nl[i*NF_MAX+k] = sat_word(longint'(lf[i*NF_MAX+k]) - stp);
			end
		for (int k = 0; k < nf; k++)
			for (j = 0; j < nc; j++) begin
				stp = (alpha * (-2 * gr[k*NC_MAX+j])) >>> 16;
				nrt[k*NC_MAX+j] = sat_word(longint'(rf[k*NC_MAX+j]) - stp);
			end
		for (i = 0; i < nr; i++)
			for (int k = 0; k < nf; k++)
				lf[i*NF_MAX+k] = nl[i*NF_MAX+k];
		for (int k = 0; k < nf; k++)
			for (j = 0; j < nc; j++)
				rf[k*NC_MAX+j] = nrt[k*NC_MAX+j];
	endtask

	// Apply one accepted request to the shadow state and queue its response
	task automatic predict_request(smf_pkg::req_t r);
		smf_pkg::rsp_t o;
		int nr, nc, nf;
		nr = clamp_cnt(rows_q, NR_MAX);
		nc = clamp_cnt(cols_q, NC_MAX);
		nf = clamp_cnt(feat_q, NF_MAX);
		o = '0;
		o.status = smf_pkg::ST_OK;
		if (r.op > smf_pkg::OP_READ)
			return;
		case (smf_pkg::op_t'(r.op))
			smf_pkg::OP_LOAD_RATING: begin
				if (r.row_index >= nr || r.col_index >= nc)
					o.status = smf_pkg::ST_RANGE;
				else if (n_stored >= RATINGS_MAX)
					o.status = smf_pkg::ST_FULL;
				else begin
					sh_row[n_stored] = r.row_index;
					sh_col[n_stored] = r.col_index;
					sh_rating[n_stored] = r.value_in;
					n_stored++;
				end
			end
			smf_pkg::OP_LOAD_LEFT: begin
				if (r.row_index >= nr || r.feature_index >= nf)
					o.status = smf_pkg::ST_RANGE;
				else
					lf[r.row_index*NF_MAX+r.feature_index] = r.value_in;
			end
			smf_pkg::OP_LOAD_RIGHT: begin
				if (r.feature_index >= nf || r.col_index >= nc)
					o.status = smf_pkg::ST_RANGE;
				else
					rf[r.feature_index*NC_MAX+r.col_index] = r.value_in;
			end
			smf_pkg::OP_RUN: begin
				for (int it = 0; it < iters_q; it++)
					descend_once(nr, nc, nf);
				o.run_done = 1'b1;
				n_runs++;
			end
			default: begin
				if (r.row_index >= nr || r.col_index >= nc)
					o.status = smf_pkg::ST_RANGE;
				else
					o.result_value = product_at(r.row_index, r.col_index, nf);
			end
		endcase
		want_rsp.push_back(o);
	endtask

	// Driver: bursts of requests separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				predict_request(req);
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_req.size() > 0) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 20);
						gap_left = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern, with one long hold-off early in the run
	int stall_cyc = 0;
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			stall_cyc++;
			if (stall_cyc % 64 == 0)
				stall_mode = $urandom_range(0, 2);
			if (stall_cyc >= HOLD_START && stall_cyc < HOLD_START + HOLD_LEN)
				rsp_stall <= 1'b1;
			else if (stall_mode == 0)
				rsp_stall <= 1'b0;
			else if (stall_mode == 1)
				rsp_stall <= $urandom_range(0, 9) < 3;
			else
				rsp_stall <= $urandom_range(0, 9) < 7;
		end
	end

	// Monitor: compare each accepted response with the oldest prediction
	always @(posedge clk) begin
		smf_pkg::rsp_t w;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (want_rsp.size() == 0) begin
				errors++;
				$display("%0t unexpected response %h", $time, rsp);
			end else begin
				w = want_rsp.pop_front();
				n_checked++;
				if (rsp.result_value !== w.result_value) begin
					errors++;
					$display("%0t result_value exp %h got %h", $time, w.result_value,
						rsp.result_value);
				end
				if (rsp.run_done !== w.run_done) begin
					errors++;
					$display("%0t run_done exp %b got %b", $time, w.run_done, rsp.run_done);
				end
				if (rsp.status !== w.status) begin
					errors++;
					$display("%0t status exp %0d got %0d", $time, w.status, rsp.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("%0t timeout, %0d responses outstanding", $time, want_rsp.size());
			$display("tb: errors");
			$finish;
		end
	end

	function automatic int pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
		if (sel < 9)
			return $urandom;
		return sel[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
	endfunction

	function automatic smf_pkg::req_t make_req(smf_pkg::op_t op, int r, int c, int f, int v);
		smf_pkg::req_t q;
		q.op = op;
		q.row_index = 8'(r);
		q.col_index = 8'(c);
		q.feature_index = 3'(f);
		q.value_in = v;
		return q;
	endfunction

	task automatic wait_idle();
		while (pending_req.size() > 0 || req_valid || want_rsp.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Write one register while the engine is idle; mirror it in the shadow copy
	task automatic write_reg(smf_pkg::cfg_reg_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			smf_pkg::REG_LEARNING_RATE: lr_q = val & 16'hFFFF;
			smf_pkg::REG_ITERATIONS: iters_q = val & 16'hFFFF;
			smf_pkg::REG_FEATURES: feat_q = val & 4'hF;
			smf_pkg::REG_ROWS: rows_q = val & 9'h1FF;
			default: cols_q = val & 9'h1FF;
		endcase
	endtask

	initial begin
		int nr, nc, nf, sel, r, c, f;
		smf_pkg::req_t q;
		bit runs_ok;
		lr_q = smf_pkg::LR_RESET;
		iters_q = smf_pkg::ITERS_RESET;
		feat_q = smf_pkg::FEAT_RESET;
		rows_q = smf_pkg::ROWS_RESET;
		cols_q = smf_pkg::COLS_RESET;
		n_stored = 0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Load the factor rows and columns that runs and reads may touch
		write_reg(smf_pkg::REG_FEATURES, NF_MAX);
		for (int i = 0; i < LOADED; i++)
			for (int k = 0; k < NF_MAX; k++) begin
				pending_req.push_back(make_req(smf_pkg::OP_LOAD_LEFT, i,
					$urandom_range(0, 255), k, $urandom_range(0, 32'h3_FFFF) - 32'h2_0000));
				pending_req.push_back(make_req(smf_pkg::OP_LOAD_RIGHT,
					$urandom_range(0, 255), i, k, $urandom_range(0, 32'h3_FFFF) - 32'h2_0000));
			end
		wait_idle();

		// Directed: extremes, range rejects, dropped ops, duplicates, zero iterations
		write_reg(smf_pkg::REG_ROWS, 16);
		write_reg(smf_pkg::REG_COLS, 16);
		write_reg(smf_pkg::REG_FEATURES, 4);
		write_reg(smf_pkg::REG_LEARNING_RATE, 16'hFFFF);
		write_reg(smf_pkg::REG_ITERATIONS, 0);
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_RATING, 0, 0, 0, 32'h7FFF_FFFF));
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_RATING, 15, 15, 7, 32'h8000_0000));
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_RATING, 0, 0, 0, 32'h0001_8000));
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_RATING, 16, 0, 0, 1));
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_LEFT, 0, 0, 3, 32'h7FFF_FFFF));
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_RIGHT, 0, 0, 3, 32'h8000_0000));
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_LEFT, 16, 0, 0, 5));
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_LEFT, 0, 0, 4, 5));
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_RIGHT, 0, 0, 4, 5));
		pending_req.push_back(make_req(smf_pkg::OP_LOAD_RIGHT, 0, 16, 0, 5));
		pending_req.push_back(make_req(smf_pkg::OP_READ, 16, 0, 0, 0));
		pending_req.push_back(make_req(smf_pkg::OP_READ, 0, 0, 0, 0));
		for (int u = 5; u < 8; u++) begin
			q = make_req(smf_pkg::OP_READ, 0, 0, 0, 0);
			q.op = 3'(u);
			pending_req.push_back(q);
		end
		pending_req.push_back(make_req(smf_pkg::OP_RUN, 0, 0, 0, 0));
		pending_req.push_back(make_req(smf_pkg::OP_READ, 15, 15, 0, 0));
		wait_idle();
		// Shrink the rows so the rating at row 15 goes stale, then run one step
		write_reg(smf_pkg::REG_ITERATIONS, 1);
		write_reg(smf_pkg::REG_ROWS, 8);
		write_reg(smf_pkg::REG_LEARNING_RATE, 500);
		pending_req.push_back(make_req(smf_pkg::OP_RUN, 0, 0, 0, 0));
		pending_req.push_back(make_req(smf_pkg::OP_READ, 0, 0, 0, 0));
		pending_req.push_back(make_req(smf_pkg::OP_READ, 7, 7, 0, 0));
		wait_idle();

		// Random phases, each under its own register setting
		for (int p = 0; p < 9; p++) begin
			write_reg(smf_pkg::REG_LEARNING_RATE, p == 0 ? 0 : (p == 1 ? 16'hFFFF :
				$urandom_range(100, 4000)));
			write_reg(smf_pkg::REG_ITERATIONS, p == 2 ? 16'hFFFF : (p == 3 ? 0 :
				$urandom_range(1, 2)));
			write_reg(smf_pkg::REG_FEATURES, p == 4 ? 0 : (p == 5 ? 15 :
				$urandom_range(1, 8)));
			write_reg(smf_pkg::REG_ROWS, p == 6 ? 0 : (p == 7 ? 511 : $urandom_range(4, 32)));
			write_reg(smf_pkg::REG_COLS, p == 6 ? 0 : (p == 7 ? 511 : $urandom_range(4, 32)));
			// Never start a run with the huge iteration count or over unloaded rows
			runs_ok = (p != 2) && (p != 7);
			nr = clamp_cnt(rows_q, NR_MAX);
			nc = clamp_cnt(cols_q, NC_MAX);
			nf = clamp_cnt(feat_q, NF_MAX);
			for (int n = 0; n < 130; n++) begin
				sel = $urandom_range(0, 99);
				r = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, nr-1);
				c = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, nc-1);
				f = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(0, nf-1);
				// Fold in-range indices back onto the loaded factors
				if (r >= LOADED && r < nr)
					r = r % LOADED;
				if (c >= LOADED && c < nc)
					c = c % LOADED;
				if (sel < 15)
					q = make_req(smf_pkg::OP_LOAD_RATING, r, c, f, pick_value());
				else if (sel < 40)
					q = make_req(smf_pkg::OP_LOAD_LEFT, r, c, f, pick_value());
				else if (sel < 65)
					q = make_req(smf_pkg::OP_LOAD_RIGHT, r, c, f, pick_value());
				else if (sel < 67 && runs_ok)
					q = make_req(smf_pkg::OP_RUN, r, c, f, $urandom);
				else if (sel < 97)
					q = make_req(smf_pkg::OP_READ, r, c, f, $urandom);
				else begin
					q = make_req(smf_pkg::OP_READ, r, c, f, $urandom);
					q.op = 3'($urandom_range(5, 7));
				end
				pending_req.push_back(q);
			end
			wait_idle();
		end

		// Wide ratings under full counts; no run follows
		write_reg(smf_pkg::REG_ROWS, 256);
		write_reg(smf_pkg::REG_COLS, 256);
		write_reg(smf_pkg::REG_FEATURES, 8);
		for (int n = 0; n < 20; n++)
			pending_req.push_back(make_req(smf_pkg::OP_LOAD_RATING, $urandom_range(0, 255),
				$urandom_range(0, 255), 0, pick_value()));
		pending_req.push_back(make_req(smf_pkg::OP_READ, LOADED - 1, LOADED - 1, 0, 0));
		pending_req.push_back(make_req(smf_pkg::OP_READ, 0, 0, 0, 0));
		wait_idle();
		repeat (100) @(posedge clk);

		$display("checked %0d responses, %0d runs, %0d ratings stored, %0d cycles",
			n_checked, n_runs, n_stored, cyc);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
